// File: rtl/core/wbi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbi_pkg
// Shared types and constants of the waveform baseline integrator.
// ----------------------------------------------------------------------------
package wbi_pkg;

  // baseline window geometry
  localparam int unsigned WINDOW      = 15;
  localparam int unsigned STEP        = 5;
  localparam int unsigned NSLOTS      = (WINDOW + STEP - 1) / STEP;
  localparam int unsigned SAMPLE_BITS = 14;

  // field and state widths
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned WIN_W     = $clog2(WINDOW + 1);
  localparam int unsigned ACC_W     = SAMPLE_BITS + WIN_W;
  localparam int unsigned RAW_W     = SAMPLE_BITS + CFG_W;
  localparam int unsigned CNT_W     = CFG_W;
  localparam int unsigned SLOT_W    = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int unsigned STEP_W    = (STEP > 1) ? $clog2(STEP) : 1;
  localparam int unsigned OUT_W     = 29;
  localparam int unsigned BASE_W    = 18;
  localparam int unsigned SCL_W     = RAW_W + WIN_W;
  localparam int unsigned PROD_W    = CNT_W + ACC_W;
  localparam int unsigned DIFF_W    = ((SCL_W > PROD_W) ? SCL_W : PROD_W) + 2;

  localparam logic [POS_W-1:0]  POS_CAP  = '1;
  localparam logic [BASE_W-1:0] BASE_MAX = '1;
  localparam logic signed [DIFF_W-1:0] OUT_MAX = DIFF_W'(268435455);

  // register reset values
  localparam logic [CFG_W-1:0] INTEG_FIRST_RST     = CFG_W'(15);
  localparam logic [CFG_W-1:0] INTEG_LIMIT_RST     = CFG_W'(90);
  localparam logic [CFG_W-1:0] BASE_LAST_START_RST = CFG_W'(70);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTEG_FIRST     = 2'd0,
    REG_INTEG_LIMIT     = 2'd1,
    REG_BASE_LAST_START = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] integ_first;
    logic [CFG_W-1:0] integ_limit;
    logic [CFG_W-1:0] base_last_start;
  } cfg_t;

  // per-waveform totals handed to the finishing stages
  typedef struct packed {
    logic [RAW_W-1:0]  raw;
    logic [CNT_W-1:0]  count;
    logic [BASE_W-1:0] base;
    logic              status;
  } fin_t;

endpackage
`default_nettype wire

// File: rtl/core/wbi_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbi channel interfaces
// Sample, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wbi_in_if;
  logic                             valid;
  logic                             ready;
  logic [wbi_pkg::SAMPLE_BITS-1:0]  sample;
  logic                             last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface wbi_out_if;
  logic                         valid;
  logic                         ready;
  logic [wbi_pkg::OUT_W-1:0]    integral_scaled;
  logic [wbi_pkg::BASE_W-1:0]   baseline_sum;
  logic                         status;

  modport source (output valid, output integral_scaled, output baseline_sum,
                  output status, input ready);
  modport sink   (input valid, input integral_scaled, input baseline_sum,
                  input status, output ready);
endinterface

interface wbi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wbi_pkg::CFG_IDX_W-1:0] index;
  logic [wbi_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/wbi_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbi_cfg_regs
// Configuration registers: integration range and last baseline window start.
// ----------------------------------------------------------------------------
module wbi_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  wbi_cfg_if.sink           cfg_ch,
  output wbi_pkg::cfg_t     cfg
);

  wbi_pkg::cfg_t cfg_r;
  wbi_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (wbi_pkg::reg_idx_t'(cfg_ch.index))
        wbi_pkg::REG_INTEG_FIRST:     cfg_nxt.integ_first     = cfg_ch.data;
        wbi_pkg::REG_INTEG_LIMIT:     cfg_nxt.integ_limit     = cfg_ch.data;
        wbi_pkg::REG_BASE_LAST_START: cfg_nxt.base_last_start = cfg_ch.data;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.integ_first     <= wbi_pkg::INTEG_FIRST_RST;
      cfg_r.integ_limit     <= wbi_pkg::INTEG_LIMIT_RST;
      cfg_r.base_last_start <= wbi_pkg::BASE_LAST_START_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/wbi_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbi_accum
// Input register and per-sample update of window sums, minimum and integral.
// ----------------------------------------------------------------------------
module wbi_accum (
  input  wire logic         clk,
  input  wire logic         rst_n,
  wbi_in_if.sink            in_ch,
  input  wire wbi_pkg::cfg_t cfg,
  output logic              fin_valid,
  output wbi_pkg::fin_t     fin,
  input  wire logic         fin_ready
);

  localparam int unsigned NS = wbi_pkg::NSLOTS;

  // input register
  logic                            in_v_r;
  logic [wbi_pkg::SAMPLE_BITS-1:0] in_sample_r;
  logic                            in_last_r;

  // waveform state
  logic [wbi_pkg::POS_W-1:0]  pos_r;
  logic [wbi_pkg::STEP_W-1:0] phase_r;
  logic [wbi_pkg::SLOT_W-1:0] slot_r;
  logic                       act_r [NS];
  logic [wbi_pkg::WIN_W-1:0]  cnt_r [NS];
  logic [wbi_pkg::ACC_W-1:0]  acc_r [NS];
  logic [wbi_pkg::ACC_W-1:0]  min_r;
  logic                       seen_r;
  logic [wbi_pkg::RAW_W-1:0]  raw_r;
  logic [wbi_pkg::CNT_W-1:0]  icnt_r;

  logic          fin_v_r;
  logic          fin_v_nxt;
  wbi_pkg::fin_t fin_r;
  wbi_pkg::fin_t fin_nxt;

  // update values
  logic                       go;
  logic                       open_any;
  logic                       open_k   [NS];
  logic                       act_upd  [NS];
  logic [wbi_pkg::WIN_W-1:0]  cnt_upd  [NS];
  logic [wbi_pkg::ACC_W-1:0]  acc_upd  [NS];
  logic [NS-1:0]              close_vec;
  logic [wbi_pkg::ACC_W-1:0]  min_upd;
  logic                       seen_upd;
  logic                       integ;
  logic [wbi_pkg::ACC_W-1:0]  base;
  logic [wbi_pkg::POS_W-1:0]  first_ext;

  assign go           = in_v_r && (!in_last_r || !fin_v_r || fin_ready);
  assign in_ch.ready  = !in_v_r || go;
  assign fin_valid    = fin_v_r;
  assign fin          = fin_r;
  assign first_ext    = wbi_pkg::POS_W'(cfg.integ_first);

  always_comb begin
    open_any = (pos_r != '0)
            && (pos_r <= wbi_pkg::POS_W'(cfg.base_last_start))
            && (phase_r == '0);
    for (int k = 0; k < NS; k++) begin
      open_k[k] = open_any && (slot_r == wbi_pkg::SLOT_W'(k));
      if (act_r[k] || open_k[k]) begin
        acc_upd[k] = (open_k[k] ? '0 : acc_r[k])
                   + wbi_pkg::ACC_W'(in_sample_r);
        cnt_upd[k] = (open_k[k] ? '0 : cnt_r[k]) + wbi_pkg::WIN_W'(1);
        close_vec[k] = (cnt_upd[k] >= wbi_pkg::WIN_W'(wbi_pkg::WINDOW));
        act_upd[k] = !close_vec[k];
      end else begin
        acc_upd[k]   = acc_r[k];
        cnt_upd[k]   = cnt_r[k];
        close_vec[k] = 1'b0;
        act_upd[k]   = 1'b0;
      end
    end

    // running minimum over complete windows
    min_upd  = min_r;
    seen_upd = seen_r;
    for (int k = 0; k < NS; k++) begin
      if (close_vec[k]) begin
        if (!seen_upd || (acc_upd[k] < min_upd)) begin
          min_upd = acc_upd[k];
        end
        seen_upd = 1'b1;
      end
    end

    integ = !in_last_r && (pos_r >= first_ext)
         && (pos_r < wbi_pkg::POS_W'(cfg.integ_limit));

    base = seen_upd ? min_upd : '0;
    fin_nxt.raw    = raw_r;
    fin_nxt.count  = icnt_r;
    fin_nxt.status = (pos_r < first_ext);
    if (base > wbi_pkg::ACC_W'(wbi_pkg::BASE_MAX)) begin
      fin_nxt.base = wbi_pkg::BASE_MAX;
    end else begin
      fin_nxt.base = wbi_pkg::BASE_W'(base);
    end

    fin_v_nxt = (fin_v_r && !fin_ready) || (go && in_last_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_sample_r <= in_ch.sample;
      in_last_r   <= in_ch.last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else begin
      fin_v_r <= fin_v_nxt;
    end
    if (go && in_last_r) begin
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && in_last_r)) begin
      pos_r   <= '0;
      phase_r <= '0;
      slot_r  <= '0;
      min_r   <= '1;
      seen_r  <= 1'b0;
      raw_r   <= '0;
      icnt_r  <= '0;
      for (int k = 0; k < NS; k++) begin
        act_r[k] <= 1'b0;
        cnt_r[k] <= '0;
        acc_r[k] <= '0;
      end
    end else if (go) begin
      if (pos_r != wbi_pkg::POS_CAP) begin
        pos_r <= pos_r + wbi_pkg::POS_W'(1);
      end
      if (pos_r != '0) begin
        if (phase_r == wbi_pkg::STEP_W'(wbi_pkg::STEP - 1)) begin
          phase_r <= '0;
          if (slot_r == wbi_pkg::SLOT_W'(NS - 1)) begin
            slot_r <= '0;
          end else begin
            slot_r <= slot_r + wbi_pkg::SLOT_W'(1);
          end
        end else begin
          phase_r <= phase_r + wbi_pkg::STEP_W'(1);
        end
      end
      min_r  <= min_upd;
      seen_r <= seen_upd;
      if (integ) begin
        raw_r  <= raw_r + wbi_pkg::RAW_W'(in_sample_r);
        icnt_r <= icnt_r + wbi_pkg::CNT_W'(1);
      end
      for (int k = 0; k < NS; k++) begin
        act_r[k] <= act_upd[k];
        cnt_r[k] <= cnt_upd[k];
        acc_r[k] <= acc_upd[k];
      end
    end
  end

`ifndef SYNTHESIS
  // staggered windows never complete together
  a_one_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r |-> $onehot0(close_vec))
    else $error("more than one baseline window closed in one cycle");

  // final sample restarts the waveform
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (go && in_last_r) |=> (pos_r == '0) && !seen_r && (icnt_r == '0))
    else $error("waveform state not cleared after final sample");

  // integrated samples are a subset of the seen ones
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wbi_pkg::POS_W'(icnt_r) <= pos_r)
    else $error("integral count ahead of sample position");
`endif

endmodule
`default_nettype wire

// File: rtl/core/wbi_finish.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbi_finish
// Scales the raw integral, subtracts count times baseline, clamps (zero for a
// short waveform) and holds the result item.
// ----------------------------------------------------------------------------
module wbi_finish (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         fin_valid,
  input  wire wbi_pkg::fin_t fin,
  output logic              fin_ready,
  wbi_out_if.source         out_ch
);

  logic                              mul_v_r;
  logic [wbi_pkg::SCL_W-1:0]         scaled_r;
  logic [wbi_pkg::PROD_W-1:0]        prod_r;
  logic [wbi_pkg::BASE_W-1:0]        mul_base_r;
  logic                              mul_status_r;

  logic                              out_v_r;
  logic [wbi_pkg::OUT_W-1:0]         out_integral_r;
  logic [wbi_pkg::OUT_W-1:0]         out_integral_nxt;
  logic [wbi_pkg::BASE_W-1:0]        out_base_r;
  logic                              out_status_r;

  logic                              out_adv;
  logic                              mul_adv;
  logic signed [wbi_pkg::DIFF_W-1:0] diff;

  assign out_adv   = !out_v_r || out_ch.ready;
  assign mul_adv   = !mul_v_r || out_adv;
  assign fin_ready = mul_adv;

  assign out_ch.valid           = out_v_r;
  assign out_ch.integral_scaled = out_integral_r;
  assign out_ch.baseline_sum    = out_base_r;
  assign out_ch.status          = out_status_r;

  always_comb begin
    diff = $signed(wbi_pkg::DIFF_W'(scaled_r)) - $signed(wbi_pkg::DIFF_W'(prod_r));
    if (mul_status_r) begin
      out_integral_nxt = '0;
    end else if (diff > wbi_pkg::OUT_MAX) begin
      out_integral_nxt = wbi_pkg::OUT_W'(wbi_pkg::OUT_MAX);
    end else if (diff < -wbi_pkg::OUT_MAX) begin
      out_integral_nxt = wbi_pkg::OUT_W'(-wbi_pkg::OUT_MAX);
    end else begin
      out_integral_nxt = wbi_pkg::OUT_W'(diff);
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else if (mul_adv) begin
      mul_v_r <= fin_valid;
    end
    if (mul_adv && fin_valid) begin
      scaled_r     <= wbi_pkg::SCL_W'(fin.raw) * wbi_pkg::SCL_W'(wbi_pkg::WINDOW);
      prod_r       <= wbi_pkg::PROD_W'(fin.count) * wbi_pkg::PROD_W'(fin.base);
      mul_base_r   <= fin.base;
      mul_status_r <= fin.status;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= mul_v_r;
    end
    if (out_adv && mul_v_r) begin
      out_integral_r <= out_integral_nxt;
      out_base_r     <= mul_base_r;
      out_status_r   <= mul_status_r;
    end
  end

`ifndef SYNTHESIS
  // a taken total always lands in the product stage
  a_fin_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_valid && fin_ready) |=> mul_v_r)
    else $error("final totals lost before product stage");

  // too-short waveform reports zero integral
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_status_r) |-> (out_integral_r == '0))
    else $error("nonzero integral with short status");

  // a waiting result item holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> out_v_r && $stable(out_integral_r)
                                   && $stable(out_base_r) && $stable(out_status_r))
    else $error("result item changed while waiting");
`endif

endmodule
`default_nettype wire

// File: rtl/core/waveform_baseline_integrator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_baseline_integrator_core
// Baseline-subtracted charge integration of one digitizer waveform at a time.
//
//   channel  dir  payload                                        role
//   in_ch    in   sample[13:0], last_sample                      waveform samples
//   out_ch   out  integral_scaled[28:0], baseline_sum[17:0],     one item per
//                 status                                         waveform
//   cfg_ch   in   index[1:0], data[9:0]                          register writes
//
// One sample is taken every cycle unless a held result stalls a final sample;
// the update of window sums, minimum and integral is one register-to-register step.
// After the final sample is taken, the result passes the sample update,
// product stage and subtract and clamp before it leaves the result register.
// Synchronous active-low reset clears all waveform state and restores the
// register defaults; no clearing pass is needed.
// A held result stalls only a final sample that reaches the full pipeline.
// ----------------------------------------------------------------------------
module waveform_baseline_integrator_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wbi_in_if.sink     in_ch,
  wbi_out_if.source  out_ch,
  wbi_cfg_if.sink    cfg_ch
);

  wbi_pkg::cfg_t cfg;
  wbi_pkg::fin_t fin;
  logic          fin_valid;
  logic          fin_ready;

  wbi_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  wbi_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_ready (fin_ready)
  );

  wbi_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_ready (fin_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
